// ===== sv/tmbp_pkg.sv =====
// Shared types and constants for the tile map background pixel block.
// No dependencies; used by tmbp_vram, tmbp_ctrl, tmbp_datapath and the top level.
package tmbp_pkg;

    localparam int VRAM_BYTES = 8192;
    localparam int VRAM_AW    = $clog2(VRAM_BYTES);
    localparam int WORD_AW    = VRAM_AW - 1;      // even/odd byte pair per word
    localparam int VRAM_WORDS = VRAM_BYTES / 2;

    localparam logic [VRAM_AW-1:0] MAP_BASE_0 = 13'h1800;
    localparam logic [VRAM_AW-1:0] MAP_BASE_1 = 13'h1C00;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SCROLL_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCROLL_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_SELECT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_UNSIGNED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE       = 3'd4;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    typedef struct packed {
        logic byte_wr;     // store accepted write word
        logic clear_wr;    // zero one memory word, advance clear pointer
        logic latch;       // capture accepted pixel request
        logic map_rd;      // read tile map entry
        logic tile_rd;     // read tile row plane pair
        logic out_load;    // load result register
    } tmbp_cmd_t;

    typedef struct packed {
        logic is_write;
        logic in_screen;
        logic clear_last;
        logic out_free;
    } tmbp_status_t;

endpackage

// ===== sv/tmbp_vram.sv =====
// Video memory: two byte-wide banks (even and odd bytes) sharing one word address.
// Depends on tmbp_pkg for sizes.
module tmbp_vram (
    input  logic                       aclk,
    input  logic                       wr_even,
    input  logic                       wr_odd,
    input  logic [tmbp_pkg::WORD_AW-1:0] wr_addr,
    input  logic [7:0]                 wr_data,
    input  logic                       rd_en,
    input  logic [tmbp_pkg::WORD_AW-1:0] rd_addr,
    output logic [7:0]                 rd_even,
    output logic [7:0]                 rd_odd
);

    logic [7:0] bank_even [tmbp_pkg::VRAM_WORDS];
    logic [7:0] bank_odd  [tmbp_pkg::VRAM_WORDS];

    always_ff @(posedge aclk) begin
        if (wr_even) begin
            bank_even[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_even <= bank_even[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_odd) begin
            bank_odd[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_odd <= bank_odd[rd_addr];
        end
    end

endmodule

// ===== sv/tmbp_ctrl.sv =====
// Sequencer for the tile map background pixel block: clear pass, accept, map read,
// tile read, result load. Depends on tmbp_pkg for command and status structs.
module tmbp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tmbp_pkg::tmbp_status_t status,
    output tmbp_pkg::tmbp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_MAP   = 5'b00100,
        ST_TILE  = 5'b01000,
        ST_SHADE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (status.is_write) begin
                        cmd.byte_wr = 1'b1;
                    end else if (status.in_screen) begin
                        cmd.latch  = 1'b1;
                        state_next = ST_MAP;
                    end
                    // off-screen pixel: accepted and dropped
                end
            end
            ST_MAP: begin
                cmd.map_rd = 1'b1;
                state_next = ST_TILE;
            end
            ST_TILE: begin
                cmd.tile_rd = 1'b1;
                state_next  = ST_SHADE;
            end
            ST_SHADE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/tmbp_datapath.sv =====
// Datapath: config registers, scroll adders, address forming, video memory,
// bit-plane select, palette lookup and result register. Depends on tmbp_pkg, tmbp_vram.
module tmbp_datapath #(
    parameter int SCREEN_COLUMNS = 160,
    parameter int SCREEN_ROWS    = 144
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tmbp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tmbp_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_req_type,
    input  logic [tmbp_pkg::VRAM_AW-1:0]        s_vram_address,
    input  logic [7:0]                          s_write_data,
    input  logic [7:0]                          s_screen_row,
    input  logic [7:0]                          s_screen_column,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_shade,
    output logic [7:0]                          m_out_row,
    output logic [7:0]                          m_out_column,
    input  tmbp_pkg::tmbp_cmd_t                 cmd,
    output tmbp_pkg::tmbp_status_t              status
);

    logic [7:0] scroll_x_reg, scroll_y_reg, palette_reg;
    logic       map_select_reg, tile_unsigned_reg;

    logic [tmbp_pkg::WORD_AW-1:0] clr_cnt_reg;

    logic [7:0] row_reg, col_reg, bg_y_reg, bg_x_reg;

    logic       m_valid_reg;
    logic [1:0] shade_reg;
    logic [7:0] out_row_reg, out_col_reg;

    logic [tmbp_pkg::VRAM_AW-1:0] map_addr;
    logic [7:0]                   tile_byte;
    logic [8:0]                   tile_num;
    logic [tmbp_pkg::WORD_AW-1:0] tile_word;
    logic [tmbp_pkg::WORD_AW-1:0] rd_addr;
    logic [7:0]                   rd_even, rd_odd;
    logic                         wr_even, wr_odd;
    logic [tmbp_pkg::WORD_AW-1:0] wr_addr;
    logic [7:0]                   wr_data;
    logic [2:0]                   bit_sel;
    logic [1:0]                   color_id;
    logic [1:0]                   shade_next;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scroll_x_reg      <= '0;
            scroll_y_reg      <= '0;
            map_select_reg    <= 1'b0;
            tile_unsigned_reg <= 1'b0;
            palette_reg       <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tmbp_pkg::REG_SCROLL_X:      scroll_x_reg      <= cfg_wr_data;
                tmbp_pkg::REG_SCROLL_Y:      scroll_y_reg      <= cfg_wr_data;
                tmbp_pkg::REG_MAP_SELECT:    map_select_reg    <= cfg_wr_data[0];
                tmbp_pkg::REG_TILE_UNSIGNED: tile_unsigned_reg <= cfg_wr_data[0];
                tmbp_pkg::REG_PALETTE:       palette_reg       <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // status
    assign status.is_write   = (s_req_type == tmbp_pkg::REQ_WRITE);
    assign status.in_screen  = ({1'b0, s_screen_row} < 9'(SCREEN_ROWS)) &&
                               ({1'b0, s_screen_column} < 9'(SCREEN_COLUMNS));
    assign status.clear_last = &clr_cnt_reg;
    assign status.out_free   = !m_valid_reg || m_ready;

    // clear pointer after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_wr) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // pixel request capture; scroll adds wrap at 8 bits
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            row_reg  <= s_screen_row;
            col_reg  <= s_screen_column;
            bg_y_reg <= s_screen_row + scroll_y_reg;
            bg_x_reg <= s_screen_column + scroll_x_reg;
        end
    end

    // memory write side: clear pass or byte store
    assign wr_even = cmd.clear_wr || (cmd.byte_wr && !s_vram_address[0]);
    assign wr_odd  = cmd.clear_wr || (cmd.byte_wr &&  s_vram_address[0]);
    assign wr_addr = cmd.clear_wr ? clr_cnt_reg : s_vram_address[tmbp_pkg::VRAM_AW-1:1];
    assign wr_data = cmd.clear_wr ? 8'h00 : s_write_data;

    // tile map entry address; byte lane picked by bg_x bit 3
    assign map_addr = (map_select_reg ? tmbp_pkg::MAP_BASE_1 : tmbp_pkg::MAP_BASE_0)
                    + {3'b000, bg_y_reg[7:3], bg_x_reg[7:3]};

    assign tile_byte = bg_x_reg[3] ? rd_odd : rd_even;
    // signed mode: numbers below 128 land at 256 and up
    assign tile_num  = {!tile_unsigned_reg && !tile_byte[7], tile_byte};
    // plane pair always starts on an even byte: one word holds lo and hi
    assign tile_word = {tile_num, bg_y_reg[2:0]};

    assign rd_addr = cmd.tile_rd ? tile_word : map_addr[tmbp_pkg::VRAM_AW-1:1];

    tmbp_vram u_vram (
        .aclk    (aclk),
        .wr_even (wr_even),
        .wr_odd  (wr_odd),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.map_rd || cmd.tile_rd),
        .rd_addr (rd_addr),
        .rd_even (rd_even),
        .rd_odd  (rd_odd)
    );

    // leftmost pixel is bit 7
    assign bit_sel  = 3'd7 - bg_x_reg[2:0];
    assign color_id = {rd_odd[bit_sel], rd_even[bit_sel]};

    always_comb begin
        case (color_id)
            2'd0:    shade_next = palette_reg[1:0];
            2'd1:    shade_next = palette_reg[3:2];
            2'd2:    shade_next = palette_reg[5:4];
            2'd3:    shade_next = palette_reg[7:6];
            default: shade_next = palette_reg[1:0];
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            shade_reg   <= shade_next;
            out_row_reg <= row_reg;
            out_col_reg <= col_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_shade      = shade_reg;
    assign m_out_row    = out_row_reg;
    assign m_out_column = out_col_reg;

endmodule

// ===== sv/tile_map_background_pixel.sv =====
// Top level of the tile map background pixel block.
// Depends on tmbp_pkg, tmbp_ctrl, tmbp_datapath (which holds tmbp_vram).
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  s_       | s_valid / s_ready    | req_type, vram_address, write_data, row, column
//  m_       | m_valid / m_ready    | shade, out_row, out_column
//  cfg_     | cfg_wr_en            | cfg_index, cfg_wr_data
//
// A write word is stored as it is accepted. A pixel word goes from accept to a loaded result
// through capture, tile map read, tile row read and palette lookup; the two dependent reads of
// the video memory's single read port set that order. Off-screen pixel words leave no result.
// After reset a clearing pass zeroes all 4096 words, one word pair per cycle, with s_ready low.
// The result register frees the sequencer; it stalls only when a new result finds it full.
module tile_map_background_pixel #(
    parameter int SCREEN_COLUMNS = 160,
    parameter int SCREEN_ROWS    = 144
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tmbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmbp_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_req_type,
    input  logic [tmbp_pkg::VRAM_AW-1:0]    s_vram_address,
    input  logic [7:0]                      s_write_data,
    input  logic [7:0]                      s_screen_row,
    input  logic [7:0]                      s_screen_column,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_shade,
    output logic [7:0]                      m_out_row,
    output logic [7:0]                      m_out_column
);

    tmbp_pkg::tmbp_cmd_t    cmd;
    tmbp_pkg::tmbp_status_t status;

    tmbp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tmbp_datapath #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_req_type      (s_req_type),
        .s_vram_address  (s_vram_address),
        .s_write_data    (s_write_data),
        .s_screen_row    (s_screen_row),
        .s_screen_column (s_screen_column),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_shade         (m_shade),
        .m_out_row       (m_out_row),
        .m_out_column    (m_out_column),
        .cmd             (cmd),
        .status          (status)
    );

endmodule

// ===== verif/tmbp_shade_checker.sv =====
// Result checker for the tile map background pixel testbench.
// Depends on tmbp_pkg; watches the config, input and result ports beside the block.
module tmbp_shade_checker
    import tmbp_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 160,
    parameter int SCREEN_ROWS    = 144
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [VRAM_AW-1:0]    s_vram_address,
    input  logic [7:0]            s_write_data,
    input  logic [7:0]            s_screen_row,
    input  logic [7:0]            s_screen_column,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [1:0]            m_shade,
    input  logic [7:0]            m_out_row,
    input  logic [7:0]            m_out_column,
    output int                    error_count,
    output int                    shades_pending,
    output int                    results_checked,
    output int                    writes_seen,
    output int                    ignored_seen
);

    typedef struct packed {
        logic [1:0] shade;
        logic [7:0] row;
        logic [7:0] column;
    } pixel_result_t;

    logic [7:0]    vram_copy [VRAM_BYTES];
    logic [7:0]    scroll_x_q;
    logic [7:0]    scroll_y_q;
    logic [7:0]    palette_q;
    logic          map_select_q;
    logic          tile_unsigned_q;
    pixel_result_t shades_due [$];
    int            mismatches;
    int            results_n;
    int            writes_n;
    int            ignored_n;

    // Background shade at a screen position, from the mirrored memory and registers.
    function automatic logic [1:0] background_shade(logic [7:0] row, logic [7:0] column);
        logic [7:0]         bg_y;
        logic [7:0]         bg_x;
        logic [VRAM_AW-1:0] map_addr;
        logic [VRAM_AW-1:0] plane_addr;
        logic [8:0]         tile_num;
        logic [7:0]         lo_plane;
        logic [7:0]         hi_plane;
        logic [2:0]         bit_pos;
        logic [1:0]         color_id;
        bg_y = row + scroll_y_q;
        bg_x = column + scroll_x_q;
        map_addr = (map_select_q ? MAP_BASE_1 : MAP_BASE_0)
                 + {3'b000, bg_y[7:3], bg_x[7:3]};
        tile_num = {1'b0, vram_copy[map_addr]};
        // signed addressing: tiles 0..127 live above the 128..255 block
        if (!tile_unsigned_q && !tile_num[7])
            tile_num[8] = 1'b1;
        plane_addr = {tile_num, bg_y[2:0], 1'b0};
        lo_plane = vram_copy[plane_addr];
        hi_plane = vram_copy[{plane_addr[VRAM_AW-1:1], 1'b1}];
        bit_pos = 3'd7 - bg_x[2:0];
        color_id = {hi_plane[bit_pos], lo_plane[bit_pos]};
        return palette_q[2*color_id +: 2];
    endfunction

    always @(posedge aclk) begin
        pixel_result_t want;
        pixel_result_t got;
        if (!aresetn) begin
            foreach (vram_copy[i])
                vram_copy[i] = 8'h00;
            scroll_x_q = 8'h00;
            scroll_y_q = 8'h00;
            palette_q = 8'h00;
            map_select_q = 1'b0;
            tile_unsigned_q = 1'b0;
            shades_due.delete();
            mismatches = 0;
            results_n = 0;
            writes_n = 0;
            ignored_n = 0;
        end else begin
            // result side first: a word accepted now cannot answer this cycle's request
            if (m_valid && m_ready) begin
                got = {m_shade, m_out_row, m_out_column};
                if (shades_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result word with nothing pending: shade %0d row %0d col %0d",
                                 $time, got.shade, got.row, got.column);
                end else begin
                    want = shades_due.pop_front();
                    results_n++;
                    if (got.shade !== want.shade || got.row !== want.row ||
                        got.column !== want.column) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("[%0t] result mismatch: expected shade %0d row %0d col %0d",
                                     $time, want.shade, want.row, want.column);
                            $display("    got shade %0d row %0d col %0d",
                                     got.shade, got.row, got.column);
                        end
                    end
                end
            end

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SCROLL_X:      scroll_x_q = cfg_wr_data;
                    REG_SCROLL_Y:      scroll_y_q = cfg_wr_data;
                    REG_MAP_SELECT:    map_select_q = cfg_wr_data[0];
                    REG_TILE_UNSIGNED: tile_unsigned_q = cfg_wr_data[0];
                    REG_PALETTE:       palette_q = cfg_wr_data;
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                if (s_req_type == REQ_WRITE) begin
                    vram_copy[s_vram_address] = s_write_data;
                    writes_n++;
                end else if (s_screen_row < SCREEN_ROWS && s_screen_column < SCREEN_COLUMNS) begin
                    shades_due.push_back({background_shade(s_screen_row, s_screen_column),
                                          s_screen_row, s_screen_column});
                end else begin
                    ignored_n++;
                end
            end
        end
        error_count <= mismatches;
        shades_pending <= shades_due.size();
        results_checked <= results_n;
        writes_seen <= writes_n;
        ignored_seen <= ignored_n;
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the tile map background pixel testbench: clock, reset, stimulus and verdict.
// Depends on tmbp_pkg, tile_map_background_pixel and tmbp_shade_checker.
module testbench;
    import tmbp_pkg::*;

    localparam int SCREEN_COLUMNS = 160;
    localparam int SCREEN_ROWS    = 144;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASES         = 8;
    localparam int PHASE_WORDS    = 116;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;

    typedef struct {
        logic               req;
        logic [VRAM_AW-1:0] addr;
        logic [7:0]         data;
        logic [7:0]         row;
        logic [7:0]         column;
    } vram_word_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_req_type;
    logic [VRAM_AW-1:0]    s_vram_address;
    logic [7:0]            s_write_data;
    logic [7:0]            s_screen_row;
    logic [7:0]            s_screen_column;
    logic                  m_valid;
    logic                  m_ready;
    logic [1:0]            m_shade;
    logic [7:0]            m_out_row;
    logic [7:0]            m_out_column;

    int error_count;
    int shades_pending;
    int results_checked;
    int writes_seen;
    int ignored_seen;

    logic [7:0] cur_sx;
    logic [7:0] cur_sy;
    logic       cur_ms;
    logic       cur_tu;
    logic       long_hold_go;
    int         burst_left;
    int         words_offered;
    int         settings_used;
    bit         steady_sender;
    int         cycle_count = 0;

    tile_map_background_pixel #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS),
        .SCREEN_ROWS   (SCREEN_ROWS)
    ) dut (.*);

    tmbp_shade_checker #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS),
        .SCREEN_ROWS   (SCREEN_ROWS)
    ) shade_monitor (.*);

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, shades_pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: m_ready follows one of four stall regimes, redrawn at random; one long hold-off on request.
    initial begin
        int cyc;
        int regime;
        int hold_left;
        bit hold_used;
        cyc = 0;
        regime = 0;
        hold_left = 0;
        hold_used = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc % 160 == 0)
                regime = $urandom_range(0, 3);
            if (long_hold_go && !hold_used) begin
                hold_used = 1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (regime)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ((cyc % 7) < 3);
                endcase
            end
        end
    end

    function automatic vram_word_t write_word(logic [VRAM_AW-1:0] addr, logic [7:0] data);
        vram_word_t w;
        w.req = REQ_WRITE;
        w.addr = addr;
        w.data = data;
        w.row = 8'($urandom);
        w.column = 8'($urandom);
        return w;
    endfunction

    function automatic vram_word_t pixel_word(logic [7:0] row, logic [7:0] column);
        vram_word_t w;
        w.req = REQ_PIXEL;
        w.addr = VRAM_AW'($urandom);
        w.data = 8'($urandom);
        w.row = row;
        w.column = column;
        return w;
    endfunction

    function automatic vram_word_t noise_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return write_word(VRAM_AW'($urandom_range(MAP_BASE_0, VRAM_BYTES - 1)), 8'($urandom));
        if (r < 45)
            return write_word(VRAM_AW'($urandom), 8'($urandom));
        if (r < 70)
            return pixel_word(8'($urandom), 8'($urandom));
        return pixel_word(8'($urandom_range(0, SCREEN_ROWS - 1)),
                          8'($urandom_range(0, SCREEN_COLUMNS - 1)));
    endfunction

    // Hold the word until accepted, then maybe end the burst with a gap.
    task automatic offer(input vram_word_t w);
        int gap;
        s_valid <= 1'b1;
        s_req_type <= w.req;
        s_vram_address <= w.addr;
        s_write_data <= w.data;
        s_screen_row <= w.row;
        s_screen_column <= w.column;
        do @(posedge aclk); while (!s_ready);
        if (w.req == REQ_WRITE || (w.row < SCREEN_ROWS && w.column < SCREEN_COLUMNS))
            words_offered++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if (steady_sender)
                gap = 0;
            else if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(10, 30);
            else
                gap = $urandom_range(0, 4);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic cfg_word(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    // Upper bits of the one-bit registers carry junk to check masking.
    task automatic apply_settings(input logic [7:0] sx, input logic [7:0] sy,
                                  input logic ms, input logic tu, input logic [7:0] pal);
        cur_sx = sx;
        cur_sy = sy;
        cur_ms = ms;
        cur_tu = tu;
        settings_used++;
        cfg_word(REG_SCROLL_X, sx);
        cfg_word(REG_SCROLL_Y, sy);
        cfg_word(REG_MAP_SELECT, {7'($urandom), ms});
        cfg_word(REG_TILE_UNSIGNED, {7'($urandom), tu});
        cfg_word(REG_UNUSED_FIRST + CFG_IDX_W'($urandom_range(0, 2)), 8'($urandom));
        cfg_word(REG_PALETTE, pal);
        cfg_wr_en <= 1'b0;
    endtask

    // Let the pipeline drain; write and off-screen words leave no result to wait for.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (shades_pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Map entry plus one tile row of planes, then pixels that land in that row.
    task automatic tile_run();
        logic [7:0]         row;
        logic [7:0]         col;
        logic [7:0]         bg_x;
        logic [7:0]         bg_y;
        logic [7:0]         tile;
        logic [VRAM_AW-1:0] map_addr;
        logic [VRAM_AW-1:0] plane;
        int                 n;
        int                 c;
        row = 8'($urandom_range(0, SCREEN_ROWS - 1));
        col = 8'($urandom_range(0, SCREEN_COLUMNS - 1));
        bg_y = row + cur_sy;
        bg_x = col + cur_sx;
        map_addr = (cur_ms ? MAP_BASE_1 : MAP_BASE_0) + {3'b000, bg_y[7:3], bg_x[7:3]};
        tile = 8'($urandom_range(0, 255));
        plane = {(!cur_tu && !tile[7]), tile, bg_y[2:0], 1'b0};
        offer(write_word(map_addr, tile));
        offer(write_word(plane, 8'($urandom)));
        offer(write_word({plane[VRAM_AW-1:1], 1'b1}, 8'($urandom)));
        n = $urandom_range(1, 4);
        repeat (n) begin
            c = int'(col) - int'(bg_x[2:0]) + int'($urandom_range(0, 7));
            if (c < 0 || c >= SCREEN_COLUMNS)
                c = col;
            offer(pixel_word(row, c[7:0]));
        end
    endtask

    initial begin
        int phase;
        int target;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_SCROLL_X;
        cfg_wr_data <= 8'h00;
        s_valid <= 1'b0;
        s_req_type <= REQ_WRITE;
        s_vram_address <= '0;
        s_write_data <= 8'h00;
        s_screen_row <= 8'h00;
        s_screen_column <= 8'h00;
        long_hold_go <= 1'b0;
        burst_left = 1;
        words_offered = 0;
        settings_used = 0;
        steady_sender = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // signed tiles, map 0, no scroll
        apply_settings(8'd0, 8'd0, 1'b0, 1'b0, 8'hE4);
        offer(write_word(13'h1800, 8'h00));
        offer(write_word(13'h1000, 8'hA5));
        offer(write_word(13'h1001, 8'h3C));
        offer(pixel_word(8'd0, 8'd0));
        offer(pixel_word(8'd0, 8'd7));
        offer(write_word(13'h1BFF, 8'h80));
        offer(pixel_word(8'd143, 8'd159));
        offer(pixel_word(8'd144, 8'd0));
        offer(pixel_word(8'd0, 8'd160));
        offer(pixel_word(8'd255, 8'd255));
        offer(write_word(13'h1FFF, 8'hFF));
        offer(write_word(13'h0000, 8'hFF));
        offer(pixel_word(8'd0, 8'd8));
        wait_idle();

        // unsigned tiles, map 1, scroll wraps both ways
        apply_settings(8'd255, 8'd255, 1'b1, 1'b1, 8'h1B);
        offer(write_word(13'h1C00, 8'h80));
        offer(write_word(13'h0800, 8'hFF));
        offer(write_word(13'h0801, 8'h00));
        offer(pixel_word(8'd1, 8'd1));
        offer(pixel_word(8'd0, 8'd0));
        offer(write_word(13'h0FFE, 8'h01));
        offer(write_word(13'h0FFF, 8'h01));
        offer(pixel_word(8'd0, 8'd0));
        offer(pixel_word(8'd143, 8'd159));

        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: apply_settings(8'd0, 8'd0, 1'b0, 1'b0, 8'h00);
                1: apply_settings(8'd255, 8'd255, 1'b1, 1'b1, 8'hFF);
                default: apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                        8'($urandom_range(0, 255)));
            endcase
            steady_sender = (phase == 5);
            // result side holds off while the sender keeps pushing
            if (phase == 3)
                long_hold_go <= 1'b1;
            target = words_offered + PHASE_WORDS;
            while (words_offered < target) begin
                if ($urandom_range(0, 9) < 6)
                    tile_run();
                else
                    offer(noise_word());
            end
        end
        wait_idle();

        $display("Checked %0d pixel results; %0d memory writes, %0d off-screen requests dropped.",
                 results_checked, writes_seen, ignored_seen);
        $display("Ran %0d register settings with bursty input, result stalls and one long hold.",
                 settings_used);
        if (error_count == 0 && shades_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/tmbp_pkg.sv
sv/tmbp_vram.sv
sv/tmbp_ctrl.sv
sv/tmbp_datapath.sv
sv/tile_map_background_pixel.sv
verif/tmbp_shade_checker.sv
verif/testbench.sv
